>>> rtl/core/tctc_pkg.sv
package tctc_pkg;

    localparam int ROW_DEPTH  = 4096;
    localparam int COL_DEPTH  = 16384;
    localparam int TILE_DEPTH = 256;

    localparam int ROW_AW  = $clog2(ROW_DEPTH);
    localparam int COL_AW  = $clog2(COL_DEPTH);
    localparam int TILE_AW = $clog2(TILE_DEPTH);

    localparam int ROW_W  = 15;
    localparam int COL_W  = 13;
    localparam int TILE_W = 12;
    localparam int TASK_W = 32;
    localparam int TOT_W  = 48;

    // wide enough for any computed row address (offset + id + 1)
    localparam int RADDR_W = 15;

    typedef enum logic [1:0] {
        OP_WR_ROW  = 2'd0,
        OP_WR_COL  = 2'd1,
        OP_WR_TILE = 2'd2,
        OP_RUN     = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  op;
        logic [13:0] index;
        logic [14:0] value;
        logic [7:0]  tile_ab;
        logic [7:0]  tile_bc;
        logic [7:0]  tile_ac;
        logic [12:0] tile_height;
    } t_req;

    typedef struct packed {
        logic [TASK_W-1:0] task_count;
        logic [TOT_W-1:0]  total_count;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TILE_AB, S_TILE_BC, S_TILE_AC, S_TILE_WAIT,
        S_ROW_AC0, S_ROW_AC1, S_ROW_AB0, S_ROW_AB1, S_ROW_WAIT,
        S_NB, S_NB_ROW0, S_NB_ROW1, S_NB_WAIT,
        S_LAST_AC, S_LAST_BC, S_LAST_WAIT,
        S_MRG_RD, S_MRG_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             row_re;
        logic [RADDR_W-1:0] row_addr;
        logic             col_re;
        logic [COL_AW:0]  col_addr_a;
        logic [COL_AW:0]  col_addr_b;
        logic             tile_re;
        logic [7:0]       tile_addr;
    } t_rd;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col_a;
        logic [COL_W-1:0]  col_b;
        logic [TILE_W-1:0] tile;
    } t_rdata;

endpackage

>>> rtl/core/tctc_if.sv
interface tctc_req_if;
    logic             valid;
    logic             ready;
    tctc_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tctc_rsp_if;
    logic             valid;
    logic             ready;
    tctc_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/tiled_csr_triangle_counter.sv
// Tiled CSR triangle counter.
// Request channel (i_req): op selects a store write (row pointer, column id,
// tile offset) or a task run. Writes are taken one per cycle and give no
// response. A task reads three tile offsets, then for each row of the tile
// walks the AB neighbors and merges the AC and BC column lists, one pair of
// column ids compared per merge step (registered reads of the column
// memory, dual read address). Requests are not taken while a task runs or
// its response is pending.
// Response channel (o_rsp): one item per task with the task count (32-bit,
// saturating) and the running total since reset (48-bit, saturating). The
// response is held in an output register until taken; a stall on it only
// delays the next request.
// Reset clears control state and the running total; store contents are
// undefined until written, no clearing pass.
module tiled_csr_triangle_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tctc_req_if.sink    i_req,
    tctc_rsp_if.source  o_rsp
);
    tctc_pkg::t_rd    rd;
    tctc_pkg::t_rdata rdata;
    tctc_pkg::t_req   r_task;
    logic busy, done;
    logic [tctc_pkg::TASK_W-1:0] count;
    logic r_vld;
    logic [tctc_pkg::TASK_W-1:0] r_task_cnt;
    logic [tctc_pkg::TOT_W-1:0]  r_total;
    logic [tctc_pkg::TOT_W:0]    sum;
    logic acc, start;

    assign i_req.ready = !busy && !r_vld;
    assign acc   = i_req.valid && i_req.ready;
    assign start = acc && i_req.data.op == tctc_pkg::OP_RUN;

    always_ff @(posedge i_clk) begin
        if (start) r_task <= i_req.data;
    end

    tctc_mem u_mem (
        .i_clk      (i_clk),
        .i_wr_op    (i_req.data.op),
        .i_wr_en    (acc),
        .i_wr_index (i_req.data.index),
        .i_wr_value (i_req.data.value),
        .i_rd       (rd),
        .o_rdata    (rdata)
    );

    tctc_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (start ? i_req.data : r_task),
        .i_rdata (rdata),
        .o_rd    (rd),
        .o_busy  (busy),
        .o_done  (done),
        .o_count (count)
    );

    assign sum = {1'b0, r_total} + (tctc_pkg::TOT_W + 1)'(count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_total <= '0;
        end else begin
            if (done) begin
                r_vld      <= 1'b1;
                r_task_cnt <= count;
                r_total    <= sum[tctc_pkg::TOT_W] ? '1 : sum[tctc_pkg::TOT_W-1:0];
            end else if (o_rsp.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    assign o_rsp.valid            = r_vld;
    assign o_rsp.data.task_count  = r_task_cnt;
    assign o_rsp.data.total_count = r_total;
endmodule

>>> rtl/core/tctc_mem.sv
module tctc_mem (
    input  logic                i_clk,
    input  logic [1:0]          i_wr_op,
    input  logic                i_wr_en,
    input  logic [13:0]         i_wr_index,
    input  logic [14:0]         i_wr_value,
    input  tctc_pkg::t_rd       i_rd,
    output tctc_pkg::t_rdata    o_rdata
);
    logic [tctc_pkg::ROW_W-1:0]  r_row  [tctc_pkg::ROW_DEPTH];
    logic [tctc_pkg::COL_W-1:0]  r_col  [tctc_pkg::COL_DEPTH];
    logic [tctc_pkg::TILE_W-1:0] r_tile [tctc_pkg::TILE_DEPTH];

    logic r_row_ok, r_cola_ok, r_colb_ok, r_tile_ok;
    logic [tctc_pkg::ROW_W-1:0]  r_row_q;
    logic [tctc_pkg::COL_W-1:0]  r_cola_q, r_colb_q;
    logic [tctc_pkg::TILE_W-1:0] r_tile_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            if (i_wr_op == tctc_pkg::OP_WR_ROW && 14'(i_wr_index) < 14'(tctc_pkg::ROW_DEPTH))
                r_row[i_wr_index[tctc_pkg::ROW_AW-1:0]] <= i_wr_value;
            if (i_wr_op == tctc_pkg::OP_WR_COL)
                r_col[i_wr_index[tctc_pkg::COL_AW-1:0]] <= i_wr_value[tctc_pkg::COL_W-1:0];
            if (i_wr_op == tctc_pkg::OP_WR_TILE && i_wr_index < 14'(tctc_pkg::TILE_DEPTH))
                r_tile[i_wr_index[tctc_pkg::TILE_AW-1:0]] <= i_wr_value[tctc_pkg::TILE_W-1:0];
        end
    end

    // out-of-range reads return zero
    always_ff @(posedge i_clk) begin
        if (i_rd.row_re) begin
            r_row_q  <= r_row[i_rd.row_addr[tctc_pkg::ROW_AW-1:0]];
            r_row_ok <= i_rd.row_addr < tctc_pkg::RADDR_W'(tctc_pkg::ROW_DEPTH);
        end
        if (i_rd.col_re) begin
            r_cola_q  <= r_col[i_rd.col_addr_a[tctc_pkg::COL_AW-1:0]];
            r_colb_q  <= r_col[i_rd.col_addr_b[tctc_pkg::COL_AW-1:0]];
            r_cola_ok <= !i_rd.col_addr_a[tctc_pkg::COL_AW];
            r_colb_ok <= !i_rd.col_addr_b[tctc_pkg::COL_AW];
        end
        if (i_rd.tile_re) begin
            r_tile_q  <= r_tile[i_rd.tile_addr];
            r_tile_ok <= 1'b1;
        end
    end

    assign o_rdata.row   = r_row_ok  ? r_row_q  : '0;
    assign o_rdata.col_a = r_cola_ok ? r_cola_q : '0;
    assign o_rdata.col_b = r_colb_ok ? r_colb_q : '0;
    assign o_rdata.tile  = r_tile_ok ? r_tile_q : '0;
endmodule

>>> rtl/core/tctc_walk.sv
module tctc_walk (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  tctc_pkg::t_req            i_req,
    input  tctc_pkg::t_rdata          i_rdata,
    output tctc_pkg::t_rd             o_rd,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [tctc_pkg::TASK_W-1:0] o_count
);
    localparam int AW = tctc_pkg::RADDR_W;
    localparam int CA = tctc_pkg::COL_AW + 1;

    tctc_pkg::t_state r_state, n_state;

    logic [tctc_pkg::TILE_W-1:0] r_ab_base, r_bc_base, r_ac_base;
    logic [12:0] r_height, r_f;
    logic [14:0] r_ac_lo, r_ac_hi, r_ab_hi, r_k, r_bc_lo, r_bc_hi, r_p, r_q;
    logic [tctc_pkg::COL_W-1:0] r_b, r_ac_last, r_bc_last;
    logic [tctc_pkg::TASK_W-1:0] r_count;

    logic [AW-1:0] ac_row, ab_row, bc_row;
    logic [13:0]   ac_row_w, ab_row_w;
    logic [13:0]   bc_row_w;
    logic [tctc_pkg::COL_W-1:0] nb_id;
    // neighbor id arrives from the column read in S_NB_ROW0, before r_b holds it
    assign nb_id    = (r_state == tctc_pkg::S_NB_ROW0) ? i_rdata.col_a : r_b;
    assign ac_row_w = 14'(r_ac_base) + 14'(r_f);
    assign ab_row_w = 14'(r_ab_base) + 14'(r_f);
    assign bc_row_w = 14'(r_bc_base) + 14'(nb_id);
    assign ac_row = AW'(ac_row_w);
    assign ab_row = AW'(ab_row_w);
    assign bc_row = AW'(bc_row_w);

    logic p_ok, q_ok;
    assign p_ok = r_p < r_ac_hi;
    assign q_ok = r_q < r_bc_hi;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tctc_pkg::S_IDLE:     if (i_start) n_state = tctc_pkg::S_TILE_AB;
            tctc_pkg::S_TILE_AB:  n_state = tctc_pkg::S_TILE_BC;
            tctc_pkg::S_TILE_BC:  n_state = tctc_pkg::S_TILE_AC;
            tctc_pkg::S_TILE_AC:  n_state = tctc_pkg::S_TILE_WAIT;
            tctc_pkg::S_TILE_WAIT:
                n_state = (r_height == 13'd0) ? tctc_pkg::S_DONE : tctc_pkg::S_ROW_AC0;
            tctc_pkg::S_ROW_AC0:  n_state = tctc_pkg::S_ROW_AC1;
            tctc_pkg::S_ROW_AC1:  n_state = tctc_pkg::S_ROW_AB0;
            tctc_pkg::S_ROW_AB0:  n_state = tctc_pkg::S_ROW_AB1;
            tctc_pkg::S_ROW_AB1:  n_state = tctc_pkg::S_ROW_WAIT;
            tctc_pkg::S_ROW_WAIT: n_state = tctc_pkg::S_NB;
            tctc_pkg::S_NB: begin
                if (r_ac_lo == r_ac_hi || r_k >= r_ab_hi)
                    n_state = (r_f + 13'd1 >= r_height) ? tctc_pkg::S_DONE
                                                        : tctc_pkg::S_ROW_AC0;
                else
                    n_state = tctc_pkg::S_NB_ROW0;
            end
            tctc_pkg::S_NB_ROW0:  n_state = tctc_pkg::S_NB_ROW1;
            tctc_pkg::S_NB_ROW1:  n_state = tctc_pkg::S_NB_WAIT;
            tctc_pkg::S_NB_WAIT:  n_state = tctc_pkg::S_LAST_AC;
            tctc_pkg::S_LAST_AC:  n_state = tctc_pkg::S_LAST_BC;
            tctc_pkg::S_LAST_BC:  n_state = tctc_pkg::S_LAST_WAIT;
            tctc_pkg::S_LAST_WAIT: n_state = tctc_pkg::S_MRG_RD;
            tctc_pkg::S_MRG_RD:
                n_state = (p_ok && q_ok) ? tctc_pkg::S_MRG_CMP : tctc_pkg::S_NB;
            tctc_pkg::S_MRG_CMP: begin
                n_state = tctc_pkg::S_MRG_RD;
                if (i_rdata.col_a < i_rdata.col_b && i_rdata.col_b > r_ac_last)
                    n_state = tctc_pkg::S_NB;
                if (i_rdata.col_a > i_rdata.col_b && i_rdata.col_a > r_bc_last)
                    n_state = tctc_pkg::S_NB;
            end
            tctc_pkg::S_DONE:     n_state = tctc_pkg::S_IDLE;
            default:              n_state = tctc_pkg::S_IDLE;
        endcase
    end

    // read requests
    always_comb begin
        o_rd = '0;
        case (r_state)
            tctc_pkg::S_TILE_AB: begin o_rd.tile_re = 1'b1; o_rd.tile_addr = i_req.tile_ab; end
            tctc_pkg::S_TILE_BC: begin o_rd.tile_re = 1'b1; o_rd.tile_addr = i_req.tile_bc; end
            tctc_pkg::S_TILE_AC: begin o_rd.tile_re = 1'b1; o_rd.tile_addr = i_req.tile_ac; end
            tctc_pkg::S_ROW_AC0: begin o_rd.row_re = 1'b1; o_rd.row_addr = ac_row; end
            tctc_pkg::S_ROW_AC1: begin o_rd.row_re = 1'b1; o_rd.row_addr = ac_row + AW'(1); end
            tctc_pkg::S_ROW_AB0: begin o_rd.row_re = 1'b1; o_rd.row_addr = ab_row; end
            tctc_pkg::S_ROW_AB1: begin o_rd.row_re = 1'b1; o_rd.row_addr = ab_row + AW'(1); end
            tctc_pkg::S_NB: begin o_rd.col_re = 1'b1; o_rd.col_addr_a = CA'(r_k); end
            tctc_pkg::S_NB_ROW0: begin o_rd.row_re = 1'b1; o_rd.row_addr = bc_row; end
            tctc_pkg::S_NB_ROW1: begin o_rd.row_re = 1'b1; o_rd.row_addr = bc_row + AW'(1); end
            tctc_pkg::S_LAST_AC: begin
                o_rd.col_re = 1'b1;
                o_rd.col_addr_a = CA'(r_ac_hi - 15'd1);
                o_rd.col_addr_b = CA'(r_bc_hi - 15'd1);
            end
            tctc_pkg::S_MRG_RD: begin
                o_rd.col_re = 1'b1;
                o_rd.col_addr_a = CA'(r_p);
                o_rd.col_addr_b = CA'(r_q);
            end
            default: o_rd = '0;
        endcase
    end

    // tile reads land in the state after the one that issued them; ordered pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tctc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            tctc_pkg::S_IDLE: begin
                r_height <= i_req.tile_height;
                r_f      <= '0;
                r_count  <= '0;
            end
            tctc_pkg::S_TILE_BC:   r_ab_base <= i_rdata.tile;
            tctc_pkg::S_TILE_AC:   r_bc_base <= i_rdata.tile;
            tctc_pkg::S_TILE_WAIT: r_ac_base <= i_rdata.tile;
            tctc_pkg::S_ROW_AC1:   r_ac_lo <= i_rdata.row;
            tctc_pkg::S_ROW_AB0:   r_ac_hi <= i_rdata.row;
            tctc_pkg::S_ROW_AB1:   r_k <= i_rdata.row;
            tctc_pkg::S_ROW_WAIT:  r_ab_hi <= i_rdata.row;
            tctc_pkg::S_NB: begin
                if (r_ac_lo == r_ac_hi || r_k >= r_ab_hi)
                    r_f <= r_f + 13'd1;
                else
                    r_k <= r_k + 15'd1;
            end
            tctc_pkg::S_NB_ROW0:   r_b <= i_rdata.col_a;
            tctc_pkg::S_NB_ROW1:   r_bc_lo <= i_rdata.row;
            tctc_pkg::S_NB_WAIT:   r_bc_hi <= i_rdata.row;
            tctc_pkg::S_LAST_AC: begin
                r_p <= r_ac_lo;
                r_q <= r_bc_lo;
            end
            tctc_pkg::S_LAST_WAIT: begin
                r_ac_last <= i_rdata.col_a;
                r_bc_last <= i_rdata.col_b;
            end
            tctc_pkg::S_MRG_CMP: begin
                if (i_rdata.col_a == i_rdata.col_b) begin
                    r_p <= r_p + 15'd1;
                    r_q <= r_q + 15'd1;
                    if (r_count != '1) r_count <= r_count + 32'd1;
                end else if (i_rdata.col_a < i_rdata.col_b) begin
                    r_p <= r_p + 15'd1;
                end else begin
                    r_q <= r_q + 15'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_busy  = r_state != tctc_pkg::S_IDLE;
    assign o_done  = r_state == tctc_pkg::S_DONE;
    assign o_count = r_count;
endmodule

>>> rtl/core/tctc_checker.sv
module tctc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic [tctc_pkg::TOT_W-1:0] i_total
);
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_total))
        else $error("response dropped while stalled");
    a_no_req_with_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request taken while response pending");
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> i_total >= $past(i_total))
        else $error("running total decreased");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");
endmodule

bind tiled_csr_triangle_counter tctc_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_total     (o_rsp.data.total_count)
);
